// File: design/xcfp_pkg.sv
package xcfp_pkg;

   // Configuration register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION_BYTE = 2'd1;

   localparam logic [7:0] START_BYTE_RESET     = 8'hAA;
   localparam logic [7:0] DIRECTION_BYTE_RESET = 8'hAF;

   // Back part hands a payload bank back to the front once the last byte of its frame is read out of the store
   typedef struct packed {
      logic valid;
      logic bank;
   } bank_release_type;

endpackage

// File: design/xcfp_ifs.sv
// Received byte stream
interface xcfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded frame stream, one beat per payload byte
interface xcfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] message_id;
   logic [5:0] payload_length;
   logic [4:0] byte_index;
   logic [7:0] payload_byte;
   logic       has_payload;
   logic       last_of_frame;

   modport source (output valid, output message_id, output payload_length,
                   output byte_index, output payload_byte, output has_payload,
                   output last_of_frame, input ready);
   modport sink   (input valid, input message_id, input payload_length,
                   input byte_index, input payload_byte, input has_payload,
                   input last_of_frame, output ready);
endinterface

// Register write channel
interface xcfp_csr_if;
   import xcfp_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [7:0]           data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/xcfp_front.sv
module xcfp_front #(
   parameter int MAX_PAYLOAD = 32,
   parameter int IDX_W       = 5,
   parameter int LEN_W       = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   xcfp_req_if.sink                      req_bus,
   xcfp_csr_if.sink                      csr_bus,
   // payload store write port
   output logic                          wr_en,
   output logic [IDX_W:0]                wr_addr,
   output logic [7:0]                    wr_data,
   // frame descriptor push {bank, length, id}
   output logic                          desc_push,
   output logic [LEN_W+8:0]              desc_data,
   input  xcfp_pkg::bank_release_type    release_bank
);
   import xcfp_pkg::*;

   typedef enum logic [5:0] {
      PH_HUNT = 6'b000001,
      PH_DIR  = 6'b000010,
      PH_ID   = 6'b000100,
      PH_LEN  = 6'b001000,
      PH_DATA = 6'b010000,
      PH_CHK  = 6'b100000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [7:0]       start_ff, start_in;
   logic [7:0]       dir_ff, dir_in;
   logic [7:0]       id_ff, id_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [7:0]       xor_ff, xor_in;
   logic             bank_ff, bank_in;
   logic [1:0]       busy_ff, busy_in;
   logic             accept;
   logic             commit;
   logic [7:0]       rx;
   logic [LEN_W-1:0] fill_next;
   logic [1:0]       rel_mask;
   logic [1:0]       set_mask;

   assign rx        = req_bus.rx_byte;
   assign fill_next = fill_ff + LEN_W'(1);

   // Hold off bytes that need the fill bank while it is still being emitted
   assign req_bus.ready = !(((phase_ff == PH_DATA) || (phase_ff == PH_CHK)) &&
                            busy_ff[bank_ff]);
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // Register writes
   always_comb begin
      start_in = start_ff;
      dir_in   = dir_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_START_BYTE:     start_in = csr_bus.data;
            CSR_DIRECTION_BYTE: dir_in   = csr_bus.data;
            default: ;
         endcase
      end
   end

   // Frame parser
   always_comb begin
      phase_in = phase_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      fill_in  = fill_ff;
      xor_in   = xor_ff;
      wr_en    = 1'b0;
      commit   = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_DIR: begin
               if (rx == dir_ff) begin
                  phase_in = PH_ID;
               end else if (rx != start_ff) begin
                  phase_in = PH_HUNT;
               end
            end
            PH_ID: begin
               id_in    = rx;
               xor_in   = rx;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               xor_in = xor_ff ^ rx;
               if (rx > 8'(MAX_PAYLOAD)) begin
                  phase_in = PH_HUNT;
               end else begin
                  len_in   = rx[LEN_W-1:0];
                  fill_in  = '0;
                  phase_in = (rx == 8'd0) ? PH_CHK : PH_DATA;
               end
            end
            PH_DATA: begin
               wr_en   = 1'b1;
               xor_in  = xor_ff ^ rx;
               fill_in = fill_next;
               if (fill_next >= len_ff) begin
                  phase_in = PH_CHK;
               end
            end
            PH_CHK: begin
               commit   = (rx == xor_ff);
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = (rx == start_ff) ? PH_DIR : PH_HUNT;
            end
         endcase
      end
   end

   assign wr_addr   = {bank_ff, fill_ff[IDX_W-1:0]};
   assign wr_data   = rx;
   assign desc_push = commit;
   assign desc_data = {bank_ff, len_ff, id_ff};

   // Bank ownership: set on a good frame, cleared when the back is done with it
   assign rel_mask = release_bank.valid ? (2'b01 << release_bank.bank) : 2'b00;
   assign set_mask = commit ? (2'b01 << bank_ff) : 2'b00;
   assign busy_in  = (busy_ff & ~rel_mask) | set_mask;
   assign bank_in  = commit ? ~bank_ff : bank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         start_ff <= START_BYTE_RESET;
         dir_ff   <= DIRECTION_BYTE_RESET;
         bank_ff  <= 1'b0;
         busy_ff  <= 2'b00;
      end else begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         dir_ff   <= dir_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      len_ff  <= len_in;
      fill_ff <= fill_in;
      xor_ff  <= xor_in;
   end

   // A frame is only committed into a bank that the back has given up
   a_commit_free_bank: assert property (@(posedge clock) disable iff (reset)
      commit |-> !busy_ff[bank_ff])
      else $error("frame committed into a busy bank");

   // The back only returns banks that are held
   a_release_busy: assert property (@(posedge clock) disable iff (reset)
      release_bank.valid |-> busy_ff[release_bank.bank])
      else $error("release of a bank that is not busy");

   // Payload writes never hit a bank that is being emitted
   a_write_free_bank: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !busy_ff[bank_ff])
      else $error("payload write into a busy bank");

endmodule

// File: design/xcfp_queue.sv
module xcfp_queue #(
   parameter int DATA_W = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              head_valid,
   output logic [DATA_W-1:0] head_data
);
   import xcfp_pkg::*;

   // Two slots: one per payload bank
   logic [DATA_W-1:0] slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign head_valid = (count_ff != 2'd0);
   assign head_data  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != 2'd2))
      else $error("descriptor queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("descriptor queue underflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("descriptor queue count out of range");

endmodule

// File: design/xcfp_back.sv
module xcfp_back #(
   parameter int IDX_W = 5,
   parameter int LEN_W = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   // payload store write port from the front
   input  logic                          wr_en,
   input  logic [IDX_W:0]                wr_addr,
   input  logic [7:0]                    wr_data,
   // head of the descriptor queue
   input  logic                          head_valid,
   input  logic [LEN_W+8:0]              head_data,
   output logic                          pop,
   output xcfp_pkg::bank_release_type    release_bank,
   xcfp_rsp_if.source                    rsp_bus
);
   import xcfp_pkg::*;

   // Double-buffered payload store, one bank per frame
   logic [7:0] store [2**(IDX_W+1)];

   logic [7:0]       head_id;
   logic [LEN_W-1:0] head_len;
   logic             head_bank;
   logic             head_last;
   logic             advance;
   logic             issue;

   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [7:0]       id_ff, id_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             has_ff, has_in;
   logic             last_ff, last_in;
   logic [7:0]       rd_data_ff;

   assign head_id   = head_data[7:0];
   assign head_len  = head_data[8 +: LEN_W];
   assign head_bank = head_data[LEN_W+8];
   assign head_last = (head_len == '0) || ((LEN_W'(k_ff) + LEN_W'(1)) == head_len);

   // Output register moves when empty or taken
   assign advance = !valid_ff || rsp_bus.ready;
   assign issue   = advance && head_valid;
   assign pop     = issue && head_last;

   assign release_bank.valid = pop;
   assign release_bank.bank  = head_bank;

   // Beat sequencer
   always_comb begin
      valid_in = advance ? head_valid : valid_ff;
      k_in     = k_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      has_in   = has_ff;
      last_in  = last_ff;
      if (issue) begin
         k_in    = head_last ? '0 : (k_ff + IDX_W'(1));
         id_in   = head_id;
         len_in  = head_len;
         idx_in  = k_ff;
         has_in  = (head_len != '0);
         last_in = head_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         k_ff     <= '0;
      end else begin
         valid_ff <= valid_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      len_ff  <= len_in;
      idx_ff  <= idx_in;
      has_ff  <= has_in;
      last_ff <= last_in;
   end

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= store[{head_bank, k_ff}];
      end
   end

   assign rsp_bus.valid          = valid_ff;
   assign rsp_bus.message_id     = id_ff;
   assign rsp_bus.payload_length = 6'(len_ff);
   assign rsp_bus.byte_index     = 5'(idx_ff);
   assign rsp_bus.payload_byte   = has_ff ? rd_data_ff : 8'd0;
   assign rsp_bus.has_payload    = has_ff;
   assign rsp_bus.last_of_frame  = last_ff;

   // Releasing a bank means the final beat of its frame was just loaded
   a_release_last: assert property (@(posedge clock) disable iff (reset)
      release_bank.valid |=> (valid_ff && last_ff))
      else $error("bank released without a last beat");

   // An empty frame is a single beat
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !has_ff) |-> last_ff)
      else $error("empty frame beat not marked last");

   // Payload beats stay inside the frame
   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && has_ff) |-> (LEN_W'(idx_ff) < len_ff))
      else $error("byte index beyond frame length");

endmodule

// File: design/xor_checked_frame_parser_top.sv
// Byte-stream deframer: hunts for the start byte and direction byte, then reads
// message id, length (up to MAX_PAYLOAD) and payload, and checks a trailing
// byte against the XOR of id, length and payload. A good frame comes out as
// one beat per payload byte (one beat with has_payload low for an empty frame),
// the last beat marked; bad or oversized frames vanish without a beat.
// The parser takes one received byte per clock. Payload goes into one of two
// banks; the parser stalls on a payload or checksum byte only while both banks
// still hold frames that have not been fully read out. Emission runs at one beat
// per clock from a registered store read, holding while rsp_bus.ready is low.
// Register writes (start_byte index 0, direction_byte index 1) are always
// accepted; other indexes are ignored.
module xor_checked_frame_parser_top #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic       clock,
   input  logic       reset,
   xcfp_req_if.sink   req_bus,
   xcfp_rsp_if.source rsp_bus,
   xcfp_csr_if.sink   csr_bus
);
   import xcfp_pkg::*;

   localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int DESC_W = LEN_W + 9;

   logic              wr_en;
   logic [IDX_W:0]    wr_addr;
   logic [7:0]        wr_data;
   logic              desc_push;
   logic [DESC_W-1:0] desc_data;
   logic              head_valid;
   logic [DESC_W-1:0] head_data;
   logic              pop;
   bank_release_type  release_bank;

   xcfp_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .IDX_W       (IDX_W),
      .LEN_W       (LEN_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .csr_bus      (csr_bus),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .desc_push    (desc_push),
      .desc_data    (desc_data),
      .release_bank (release_bank)
   );

   xcfp_queue #(
      .DATA_W (DESC_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (desc_push),
      .push_data  (desc_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   xcfp_back #(
      .IDX_W (IDX_W),
      .LEN_W (LEN_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .head_valid   (head_valid),
      .head_data    (head_data),
      .pop          (pop),
      .release_bank (release_bank),
      .rsp_bus      (rsp_bus)
   );

endmodule
